/* src/sorted_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// Sorted priority queue: assertion macros
// Shared macro forms for the concurrent checks of the queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, clocked on clock, muted during reset
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, muted during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, transfer structs, op and status codes shared by the queue files.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int DEPTH        = 16;
   localparam int PAYLOAD_BITS = 64;
   localparam int RANK_W       = 16;
   localparam int TAG_W        = 64;
   localparam int FILL_W       = 5;
   localparam int CNT_W        = $clog2(DEPTH + 1);

   // Request op codes
   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_PUSHED = 2'd0,
      STATUS_POPPED = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic                     req_type;
      logic signed [RANK_W-1:0] rank;
      logic [TAG_W-1:0]         tag_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [TAG_W-1:0]         head_tag;
      logic signed [RANK_W-1:0] head_rank;
      logic [FILL_W-1:0]        fill_level;
   } rsp_item_type;

   // One stored entry
   typedef struct packed {
      logic signed [RANK_W-1:0] rank;
      logic [PAYLOAD_BITS-1:0]  tag;
   } entry_type;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic signed [RANK_W-1:0] rank;
      logic [PAYLOAD_BITS-1:0]  tag;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* src/spq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
   input  wire logic                   clock,
   input  wire spq_pkg::cell_ctrl_type ctrl,
   input  wire logic                   occupied,
   input  wire logic                   prev_keep,
   input  wire spq_pkg::entry_type     prev_entry,
   input  wire spq_pkg::entry_type     next_entry,
   output logic                        keep,
   output spq_pkg::entry_type          entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // Keep the stored entry when occupied and it ranks equal or higher than the new one
   assign keep  = occupied && ($signed(entry_ff.rank) >= $signed(ctrl.rank));
   assign entry = entry_ff;

   // Choose next contents: hold, insert, shift down on push, shift up on pop
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in.rank = ctrl.rank;
            entry_in.tag  = ctrl.tag;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctrl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

/* src/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept sorted by rank in a chain of cells, highest rank first.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data): req_type selects
//   enqueue of (rank, tag_value) or dequeue of the head entry. Equal ranks
//   leave in arrival order.
//   Result channel (rsp_valid / rsp_stall / rsp_data): one result per
//   request with status, the removed entry on a dequeue and the fill level.
//   The result is registered: a request transferred at one edge shows its
//   result from the next cycle. Throughput is one request per cycle while
//   no result is held by rsp_stall; every cell compares against the broadcast
//   rank and shifts in the same cycle; chain length sets compare fan-out, not rate.
//   The single output register holds a result while rsp_stall is high; the
//   request side then stalls until that result transfers, and resumes in the
//   same cycle it does.
//   Reset empties the queue (fill level zero) and drops any pending result;
//   cell contents are not cleared and are never read before being written.
//   A full queue refuses an enqueue; an empty queue answers a dequeue with
//   status empty. Both leave the contents unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire spq_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output spq_pkg::rsp_item_type      rsp_data
);

   logic [spq_pkg::CNT_W-1:0] count_ff;
   logic [spq_pkg::CNT_W-1:0] count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   spq_pkg::rsp_item_type     rsp_ff;
   spq_pkg::rsp_item_type     rsp_in;

   logic                      accept;
   logic                      is_full;
   logic                      is_empty;
   spq_pkg::cell_ctrl_type    ctrl;
   logic                      keep       [spq_pkg::DEPTH];
   spq_pkg::entry_type        cell_entry [spq_pkg::DEPTH];

   // Stall the request side only while a held result cannot transfer
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == spq_pkg::CNT_W'(spq_pkg::DEPTH));
   assign is_empty  = (count_ff == '0);

   // Broadcast the operation to the chain
   always_comb begin
      ctrl.push = accept && (req_data.req_type == spq_pkg::REQ_ENQUEUE) && !is_full;
      ctrl.pop  = accept && (req_data.req_type == spq_pkg::REQ_DEQUEUE) && !is_empty;
      ctrl.rank = req_data.rank;
      ctrl.tag  = req_data.tag_value[spq_pkg::PAYLOAD_BITS-1:0];
   end

   // Build the chain of cells
   for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
      logic               prev_keep;
      spq_pkg::entry_type prev_entry;
      spq_pkg::entry_type next_entry;

      if (i == 0) begin : g_head
         assign prev_keep  = 1'b1;
         assign prev_entry = {ctrl.rank, ctrl.tag};
      end else begin : g_body
         assign prev_keep  = keep[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == spq_pkg::DEPTH - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_link
         assign next_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (spq_pkg::CNT_W'(i) < count_ff),
         .prev_keep  (prev_keep),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .keep       (keep[i]),
         .entry      (cell_entry[i])
      );
   end

   // Update the fill count and form the result
   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + spq_pkg::CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - spq_pkg::CNT_W'(1);
      end

      rsp_in            = '0;
      rsp_in.fill_level = spq_pkg::FILL_W'(count_in);
      if (req_data.req_type == spq_pkg::REQ_ENQUEUE) begin
         rsp_in.status = is_full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_PUSHED;
      end else if (is_empty) begin
         rsp_in.status = spq_pkg::STATUS_EMPTY;
      end else begin
         rsp_in.status    = spq_pkg::STATUS_POPPED;
         rsp_in.head_tag  = spq_pkg::TAG_W'(cell_entry[0].tag);
         rsp_in.head_rank = cell_entry[0].rank;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result register on each request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* src/spq_checker.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on results and the result handshake, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_defines.svh"

module spq_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire spq_pkg::rsp_item_type rsp_data
);

   logic rsp_pushed;
   logic rsp_empty;
   logic rsp_full;
   logic req_done;
   logic rsp_held;

   assign rsp_pushed = rsp_valid && (rsp_data.status == spq_pkg::STATUS_PUSHED);
   assign rsp_empty  = rsp_valid && (rsp_data.status == spq_pkg::STATUS_EMPTY);
   assign rsp_full   = rsp_valid && (rsp_data.status == spq_pkg::STATUS_FULL);
   assign req_done   = req_valid && !req_stall;
   assign rsp_held   = rsp_valid && rsp_stall;

   // Only a dequeue that removed an entry carries a tag and rank
   `SPQ_ASSERT_SAME(a_no_head_unless_popped, rsp_pushed || rsp_empty || rsp_full, (rsp_data.head_tag == '0) && (rsp_data.head_rank == '0), "head fields set without a dequeue")

   // An empty answer reports no stored entries
   `SPQ_ASSERT_SAME(a_empty_level, rsp_empty, rsp_data.fill_level == '0, "empty result with nonzero fill level")

   // A refused enqueue reports a full queue
   `SPQ_ASSERT_SAME(a_full_level, rsp_full, rsp_data.fill_level == spq_pkg::FILL_W'(spq_pkg::DEPTH), "full result below capacity")

   // Every request transfer gives a result in the next cycle
   `SPQ_ASSERT_NEXT(a_result_follows, req_done, rsp_valid, "request transferred without a result")

   // Hold a stalled result unchanged until it transfers
   `SPQ_ASSERT_NEXT(a_stall_holds, rsp_held, rsp_valid && $stable(rsp_data), "stalled result changed or dropped")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
